// File: src/cpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg: shared types and constants for the color palette indexer
// Pixel and result item layouts, cell control and sizing of the color chain.
// ----------------------------------------------------------------------------
package cpi_pkg;

  localparam int TABLE_ENTRIES  = 256;
  localparam int COMPONENT_BITS = 16;

  // Fixed widths of the item fields
  localparam int PIX_W      = 16;
  localparam int IDX_OUT_W  = 8;
  localparam int SIZE_OUT_W = 9;

  // Cell position and fill count widths
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Match reduction: cells are grouped, each group is OR-ed into one register
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef struct packed {
    logic [PIX_W-1:0] pix_red;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_blue;
    logic             last_pixel;
  } pix_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  palette_index;
    logic                  new_entry;
    logic                  overflow;
    logic [SIZE_OUT_W-1:0] palette_size;
    logic                  last_out;
  } res_t;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] r;
    logic [COMPONENT_BITS-1:0] g;
    logic [COMPONENT_BITS-1:0] b;
  } color_t;

  typedef struct packed {
    logic cmp_en;    // register the match of the broadcast color
    logic shift_en;  // move every entry one cell down, take a new one at the head
    logic clear;     // drop all entries
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FINISH
  } state_t;

endpackage

// File: src/color_palette_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_palette_indexer: palette indexing of an RGB pixel stream
// Finds each pixel's color in a chain of palette cells, appends unseen colors
// and reports index, new-entry, overflow and palette size.
// ----------------------------------------------------------------------------
// For each pixel, the accepting edge registers the match in every cell of the
// chain, the group registers of the reduce state then fold the matches, and
// the finish state resolves the index and loads the result register,
// holding while that register still carries an untaken result; the next pixel
// is accepted on the cycle after that. New colors are pushed in at the head of
// the chain, so the cell at position p holds palette index count-1-p. The last
// pixel of an image drops all entries at once; there is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module color_palette_indexer
  import cpi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_stall,
  input  pix_t pix,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  color_t           pix_color;
  logic             pix_last;
  color_t           in_color;
  logic             accept;
  logic             res_load;
  res_t             res_next;
  cell_ctrl_t       ctrl;

  color_t                   chain_color [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] chain_valid;
  logic [TABLE_ENTRIES-1:0] hits;
  logic [NUM_GROUPS-1:0]    grp_hit;
  logic [IDX_W-1:0]         grp_pos [NUM_GROUPS];

  logic             found;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] index;
  logic             full;

  assign pix_stall = (state != ST_IDLE);
  assign accept    = pix_valid && !pix_stall;

  // Only the low component bits take part in matching and storing
  assign in_color.r = pix.pix_red[COMPONENT_BITS-1:0];
  assign in_color.g = pix.pix_green[COMPONENT_BITS-1:0];
  assign in_color.b = pix.pix_blue[COMPONENT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_color <= in_color;
      pix_last  <= pix.last_pixel;
    end
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    color_t prev_color;
    logic   prev_valid;

    if (k == 0) begin : g_head
      assign prev_color = pix_color;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_color = chain_color[k-1];
      assign prev_valid = chain_valid[k-1];
    end

    cpi_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pix        (in_color),
      .prev_color (prev_color),
      .prev_valid (prev_valid),
      .color      (chain_color[k]),
      .valid      (chain_valid[k]),
      .hit        (hits[k])
    );
  end

  cpi_reduce u_reduce (
    .clk     (clk),
    .hits    (hits),
    .grp_hit (grp_hit),
    .grp_pos (grp_pos)
  );

  always_comb begin
    pos = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      pos = pos | grp_pos[g];
    end
  end

  assign found = |grp_hit;
  assign full  = (count == CNT_W'(TABLE_ENTRIES));
  assign index = count - CNT_W'(1) - CNT_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ctrl.cmp_en  = accept;
    ctrl.shift_en = 1'b0;
    ctrl.clear   = 1'b0;
    res_load     = 1'b0;
    res_next     = '0;
    res_next.last_out = pix_last;

    if (found) begin
      res_next.palette_index = IDX_OUT_W'(index);
      res_next.palette_size  = SIZE_OUT_W'(count);
    end else if (!full) begin
      res_next.palette_index = IDX_OUT_W'(count);
      res_next.new_entry     = 1'b1;
      res_next.palette_size  = SIZE_OUT_W'(count + CNT_W'(1));
    end else begin
      res_next.overflow     = 1'b1;
      res_next.palette_size = SIZE_OUT_W'(count);
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          if (pix_last) begin
            ctrl.clear = 1'b1;
            count_next = '0;
          end else if (!found && !full) begin
            ctrl.shift_en = 1'b1;
            count_next    = count + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// File: src/cpi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_cell: one palette entry of the color chain
// Holds a color and its valid bit, matches it against the broadcast pixel and
// takes its neighbor's entry when a new color is pushed in at the head.
// ----------------------------------------------------------------------------
module cpi_cell
  import cpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  color_t     pix,
  input  color_t     prev_color,
  input  logic       prev_valid,
  output color_t     color,
  output logic       valid,
  output logic       hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (ctrl.shift_en) begin
        valid <= prev_valid;
      end
      if (ctrl.cmp_en) begin
        hit <= valid && (color == pix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      color <= prev_color;
    end
  end

endmodule

// File: src/cpi_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_reduce: registered match reduction over the color chain
// Folds the hit bits of each group of cells into a group hit and the position
// of the matching cell. Entries are unique, so at most one cell hits.
// ----------------------------------------------------------------------------
module cpi_reduce
  import cpi_pkg::*;
(
  input  logic                     clk,
  input  logic [TABLE_ENTRIES-1:0] hits,
  output logic [NUM_GROUPS-1:0]    grp_hit,
  output logic [IDX_W-1:0]         grp_pos [NUM_GROUPS]
);

  localparam int PAD = NUM_GROUPS * GROUP_SIZE;

  logic [PAD-1:0] hits_pad;

  assign hits_pad = PAD'(hits);

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic             any;
    logic [IDX_W-1:0] pos;

    always_comb begin
      any = 1'b0;
      pos = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (hits_pad[g*GROUP_SIZE + k]) begin
          any = 1'b1;
          pos = pos | IDX_W'(g*GROUP_SIZE + k);
        end
      end
    end

    always_ff @(posedge clk) begin
      grp_hit[g] <= any;
      grp_pos[g] <= pos;
    end
  end

endmodule

// File: verif/tb_color_palette_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_palette_indexer: self-checking bench for the color palette indexer
// Streams images of RGB pixels through the block and predicts each palette
// index, new-entry and overflow flag and palette size from its own table of
// seen colors. Covers small images with repeated and near-miss colors, plus
// images that fill the table and run into overflow. Both handshake sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_color_palette_indexer;
  import cpi_pkg::*;

  localparam int RGB_W      = 3 * PIX_W;
  localparam int NUM_PIXELS = 1300;
  localparam int HANG_LIMIT = 2000;

  // Tracks the palette of the current image and the results it implies
  class palette_tracker;
    logic [3*COMPONENT_BITS-1:0] colors[TABLE_ENTRIES];
    int unsigned                 fill;
    res_t                        pending_results[$];
    int unsigned                 mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void note_pixel(pix_t p);
      logic [3*COMPONENT_BITS-1:0] key;
      int unsigned idx;
      int unsigned i;
      bit          found;
      res_t        r;
      // only the low COMPONENT_BITS of each component take part
      key   = {p.pix_red[COMPONENT_BITS-1:0], p.pix_green[COMPONENT_BITS-1:0],
               p.pix_blue[COMPONENT_BITS-1:0]};
      found = 1'b0;
      idx   = 0;
      r     = '0;
      for (i = 0; i < fill; i++) begin
        if (!found && colors[i] == key) begin
          idx   = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (fill < TABLE_ENTRIES) begin
          colors[fill] = key;
          idx          = fill;
          fill++;
          r.new_entry  = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      r.palette_index = idx[IDX_OUT_W-1:0];
      r.palette_size  = fill[SIZE_OUT_W-1:0];
      r.last_out      = p.last_pixel;
      if (p.last_pixel) fill = 0;
      pending_results = {pending_results, r};
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t act);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        return;
      end
      want = pending_results.pop_front();
      field_ok("palette_index", want.palette_index, act.palette_index);
      field_ok("new_entry", want.new_entry, act.new_entry);
      field_ok("overflow", want.overflow, act.overflow);
      field_ok("palette_size", want.palette_size, act.palette_size);
      field_ok("last_out", want.last_out, act.last_out);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  pix_t pix;
  logic res_valid;
  logic res_stall;
  res_t res;

  palette_tracker tracker;
  bit             idle_en;
  int unsigned    pixels_sent;
  int unsigned    hang_count;

  color_palette_indexer u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check each accepted item, stall at random
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) tracker.check_result(res);
      res_stall <= idle_en && ($urandom_range(99) < 7);
    end
  end

  // Abort when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst) begin
      hang_count <= 0;
    end else if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  function automatic logic [RGB_W-1:0] random_rgb();
    return {PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom)};
  endfunction

  task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic last);
    pix_t p;
    p.pix_red    = rgb[3*PIX_W-1:2*PIX_W];
    p.pix_green  = rgb[2*PIX_W-1:PIX_W];
    p.pix_blue   = rgb[PIX_W-1:0];
    p.last_pixel = last;
    while (idle_en && $urandom_range(99) < 7) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    // hold the item until an edge sees it without stall
    do @(posedge clk); while (pix_stall);
    tracker.note_pixel(p);
    pixels_sent++;
  endtask

  // Few colors, many repeats, some one-bit near misses and fresh colors
  task automatic send_small_image();
    logic [RGB_W-1:0] pool[$];
    logic [RGB_W-1:0] rgb;
    int               len;
    int               k;
    int               roll;
    len = $urandom_range(1, 40);
    repeat ($urandom_range(1, 16)) pool = {pool, random_rgb()};
    for (k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll < 70) rgb = pool[$urandom_range(pool.size() - 1)];
      else if (roll < 85)
        rgb = pool[$urandom_range(pool.size() - 1)] ^ (RGB_W'(1) << $urandom_range(RGB_W - 1));
      else rgb = random_rgb();
      send_pixel(rgb, k == len - 1);
    end
  endtask

  // Fill the table, then mix stored colors with unseen ones that overflow
  task automatic send_full_image();
    logic [RGB_W-1:0] pool[$];
    logic [RGB_W-1:0] rgb;
    int               k;
    for (k = 0; k < 300; k++) begin
      if (k < TABLE_ENTRIES || k[0]) begin
        rgb = random_rgb();
        if (k < TABLE_ENTRIES) pool = {pool, rgb};
      end else begin
        rgb = pool[$urandom_range(pool.size() - 1)];
      end
      send_pixel(rgb, k == 299);
    end
  endtask

  initial begin
    tracker     = new();
    idle_en     = 1'b1;
    pixels_sent = 0;
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, repeats, single-pixel images, back-to-back images
    send_pixel({3{PIX_W'(0)}}, 1'b0);
    send_pixel({3{{PIX_W{1'b1}}}}, 1'b0);
    send_pixel({3{PIX_W'(0)}}, 1'b0);
    send_pixel({{PIX_W{1'b1}}, PIX_W'(0), PIX_W'(0)}, 1'b0);
    send_pixel({PIX_W'(0), {PIX_W{1'b1}}, PIX_W'(0)}, 1'b0);
    send_pixel({PIX_W'(0), PIX_W'(0), {PIX_W{1'b1}}}, 1'b0);
    send_pixel({3{{PIX_W{1'b1}}}}, 1'b0);
    send_pixel({PIX_W'(1), PIX_W'(0), PIX_W'(0)}, 1'b0);
    send_pixel({PIX_W'(1), PIX_W'(0), PIX_W'(0)}, 1'b1);
    send_pixel({3{PIX_W'(5)}}, 1'b1);
    send_pixel({3{PIX_W'(5)}}, 1'b1);
    send_pixel({3{{PIX_W{1'b1}}}}, 1'b0);
    send_pixel({3{PIX_W'(0)}}, 1'b0);
    send_pixel({3{{PIX_W{1'b1}}}}, 1'b1);

    while (pixels_sent < 350) send_small_image();
    // long stretch with no idling on either side
    idle_en = 1'b0;
    send_full_image();
    while (pixels_sent < 800) send_small_image();
    idle_en = 1'b1;
    send_full_image();
    while (pixels_sent < NUM_PIXELS) send_small_image();
    pix_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
